[rtl/cdad_pkg.sv]
// shared types, constants and calendar tables for the date adder
package cdad_pkg;

	// division of a year by one hundred through a reciprocal multiply
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int          DIV100_SHIFT = 19;
	localparam logic [15:0] CENTURY      = 16'd100;

	localparam logic [9:0] YEAR_DAYS      = 10'd365;
	localparam logic [9:0] LEAP_YEAR_DAYS = 10'd366;
	localparam logic [4:0] LEAP_FEB_DAYS  = 5'd29;
	localparam logic [4:0] FEB_DAYS       = 5'd28;
	localparam logic [3:0] FEBRUARY       = 4'd2;
	localparam logic [3:0] JANUARY        = 4'd1;
	localparam logic [3:0] LAST_MONTH     = 4'd12;

	typedef struct packed {
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [13:0] start_year;
		logic [8:0]  add_days;
	} cdad_query_t;

	typedef struct packed {
		logic        is_leap;
		logic [8:0]  day_of_year;
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [13:0] out_year;
	} cdad_answer_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEAP_MUL,
		ST_LEAP_EVAL,
		ST_ORDINAL,
		ST_YEAR_CHECK,
		ST_MONTH,
		ST_DONE
	} cdad_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic leap_mul;
		logic leap_eval;
		logic leap_first;
		logic ordinal;
		logic year_step;
		logic month_step;
		logic out_load;
	} cdad_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic year_over;
		logic month_more;
	} cdad_status_t;

	// length of a month inside the search, months one to twelve
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m) inside
			FEBRUARY:                  len = leap ? LEAP_FEB_DAYS : FEB_DAYS;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// days in the months before a month, months above twelve count the whole year
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		unique case (m) inside
			4'd0, 4'd1: d = 9'd0;
			4'd2:       d = 9'd31;
			4'd3:       d = 9'd59;
			4'd4:       d = 9'd90;
			4'd5:       d = 9'd120;
			4'd6:       d = 9'd151;
			4'd7:       d = 9'd181;
			4'd8:       d = 9'd212;
			4'd9:       d = 9'd243;
			4'd10:      d = 9'd273;
			4'd11:      d = 9'd304;
			4'd12:      d = 9'd334;
			[4'd13:4'd15]: d = 9'd365;
			default:    d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

[rtl/cdad_ctrl.sv]
// sequencer for the date adder: leap test, year rollover and month search
module cdad_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  query_valid,
	output logic                  query_stall,
	output logic                  answer_valid,
	input  logic                  answer_stall,
	input  cdad_pkg::cdad_status_t status,
	output cdad_pkg::cdad_cmd_t    cmd
);
	import cdad_pkg::*;

	cdad_state_t state_q;
	cdad_state_t state_next;
	logic        first_q;
	logic        answer_valid_q;
	logic        out_free;

	assign out_free = !answer_valid_q || !answer_stall;

	// state register and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			first_q        <= 1'b0;
			answer_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load) begin
				first_q <= 1'b1;
			end else if (cmd.leap_eval) begin
				first_q <= 1'b0;
			end
			if (cmd.out_load) begin
				answer_valid_q <= 1'b1;
			end else if (!answer_stall) begin
				answer_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (query_valid) state_next = ST_LEAP_MUL;
			end
			ST_LEAP_MUL:   state_next = ST_LEAP_EVAL;
			ST_LEAP_EVAL:  state_next = first_q ? ST_ORDINAL : ST_YEAR_CHECK;
			ST_ORDINAL:    state_next = ST_YEAR_CHECK;
			ST_YEAR_CHECK: state_next = status.year_over ? ST_LEAP_MUL : ST_MONTH;
			ST_MONTH: begin
				if (!status.month_more) state_next = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_next = ST_IDLE;
			end
			default:       state_next = ST_IDLE;
		endcase
	end

	// datapath commands and handshake outputs
	always_comb begin
		cmd            = '0;
		query_stall    = (state_q != ST_IDLE);
		answer_valid   = answer_valid_q;
		unique case (state_q)
			ST_IDLE:       cmd.load = query_valid;
			ST_LEAP_MUL:   cmd.leap_mul = 1'b1;
			ST_LEAP_EVAL: begin
				cmd.leap_eval  = 1'b1;
				cmd.leap_first = first_q;
			end
			ST_ORDINAL:    cmd.ordinal = 1'b1;
			ST_YEAR_CHECK: cmd.year_step = status.year_over;
			ST_MONTH:      cmd.month_step = status.month_more;
			ST_DONE:       cmd.out_load = out_free;
			default:       cmd = '0;
		endcase
	end

endmodule

[rtl/cdad_dpath.sv]
// datapath of the date adder: leap unit, ordinal sum, year and month reduction
module cdad_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cdad_pkg::cdad_query_t  query,
	input  cdad_pkg::cdad_cmd_t    cmd,
	output cdad_pkg::cdad_status_t status,
	output cdad_pkg::cdad_answer_t answer
);
	import cdad_pkg::*;

	logic [4:0]   day_q;
	logic [3:0]   month_q;
	logic [8:0]   add_q;
	logic [14:0]  year_q;
	logic [27:0]  prod_q;
	logic         leap0_q;
	logic         year_leap_q;
	logic [8:0]   doy_q;
	logic [9:0]   n_q;
	logic [3:0]   m_q;
	cdad_answer_t answer_q;

	logic [8:0]  cent;
	logic [15:0] cent_x100;
	logic [15:0] cent_rem;
	logic        leap;
	logic        late_month;
	logic [8:0]  doy;
	logic [9:0]  year_len;
	logic [4:0]  mon_len;

	// leap test: quotient by one hundred from the registered product
	always_comb begin
		cent       = prod_q[27:DIV100_SHIFT];
		cent_x100  = 16'(cent) * CENTURY;
		cent_rem   = 16'(year_q) - cent_x100;
		leap       = (year_q[1:0] == 2'b00) && ((cent_rem != 16'd0) || (cent[1:0] == 2'b00));
	end

	// ordinal day of the start date
	always_comb begin
		late_month = month_q > FEBRUARY;
		doy        = days_before(month_q) + 9'(day_q) + 9'(leap0_q && late_month);
	end

	// lengths of the current year and month
	always_comb begin
		year_len          = year_leap_q ? LEAP_YEAR_DAYS : YEAR_DAYS;
		mon_len           = month_len(m_q, year_leap_q);
		status.year_over  = n_q > year_len;
		status.month_more = (m_q < LAST_MONTH) && (n_q > 10'(mon_len));
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_q   <= query.start_day;
			month_q <= query.start_month;
			add_q   <= query.add_days;
			year_q  <= 15'(query.start_year);
			m_q     <= JANUARY;
		end
		if (cmd.leap_mul) begin
			prod_q <= 28'(year_q) * 28'(DIV100_MUL);
		end
		if (cmd.leap_eval) begin
			year_leap_q <= leap;
			if (cmd.leap_first) leap0_q <= leap;
		end
		if (cmd.ordinal) begin
			doy_q <= doy;
			n_q   <= 10'(doy) + 10'(add_q);
		end
		if (cmd.year_step) begin
			n_q    <= n_q - year_len;
			year_q <= year_q + 15'd1;
		end
		if (cmd.month_step) begin
			n_q <= n_q - 10'(mon_len);
			m_q <= m_q + 4'd1;
		end
		if (cmd.out_load) begin
			answer_q.is_leap     <= leap0_q;
			answer_q.day_of_year <= doy_q;
			answer_q.out_day     <= n_q[4:0];
			answer_q.out_month   <= m_q;
			answer_q.out_year    <= year_q[13:0];
		end
	end

	assign answer = answer_q;

`ifndef ASSERT_OFF
	a_month_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.month_step |-> (m_q != 4'd0) && (m_q < LAST_MONTH))
		else $error("month step outside january to november");
	a_year_step_needed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.year_step |-> n_q > YEAR_DAYS)
		else $error("year step with ordinal inside the year");
	a_out_day_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> n_q <= 10'd31)
		else $error("result day beyond a month");
	a_out_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (m_q != 4'd0) && (m_q <= LAST_MONTH))
		else $error("result month outside one to twelve");
`endif

endmodule

[rtl/calendar_date_add_days.sv]
// top level of the gregorian date adder
//
// query channel: one start date (day, month, year) and a day count per transfer,
// taken when query_valid is high and query_stall is low. query_stall is high
// whenever an item is in work, so one item is handled at a time.
// answer channel: leap flag and ordinal day of the start date plus the date that
// many days later, shown on answer while answer_valid is high; a transfer
// completes when answer_stall is low.
// after the query transfer the leap unit (a registered reciprocal multiply, then
// the leap evaluation) and the ordinal sum run, then the year check; each of the
// k (0 to 2) year rollovers reruns the leap unit and the year check. the month
// search then steps one month per cycle, and its result is registered on answer.
// a second rollover leaves at most 146 days, so the search then ends by may.
// the next query can be taken in the same cycle that answer_valid rises.
// the answer sits in an output register, so a new query is taken while a result
// still waits; a finished item waits in its last step only while that register
// is still held by a stalled answer.
// reset clears the sequencer and the answer valid flag; no clearing pass.
module calendar_date_add_days (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  query_valid,
	output logic                  query_stall,
	input  cdad_pkg::cdad_query_t  query,
	output logic                  answer_valid,
	input  logic                  answer_stall,
	output cdad_pkg::cdad_answer_t answer
);
	import cdad_pkg::*;

	cdad_cmd_t    cmd;
	cdad_status_t status;

	// sequencer
	cdad_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_stall  (query_stall),
		.answer_valid (answer_valid),
		.answer_stall (answer_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// arithmetic and result register
	cdad_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query),
		.cmd    (cmd),
		.status (status),
		.answer (answer)
	);

endmodule
